// ===== sv/http_header_field_extractor_macros.svh =====
// assertion macros for the http header field extractor
`ifndef HTTP_HEADER_FIELD_EXTRACTOR_MACROS_SVH
`define HTTP_HEADER_FIELD_EXTRACTOR_MACROS_SVH

`ifndef SYNTHESIS
`define HHFE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hhfe assertion failed");
`define HHFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hhfe assertion failed");
`else
`define HHFE_ASSERT_IMPL(label, ante, cons)
`define HHFE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/hhfe_pkg.sv =====
`timescale 1ns / 1ps

package hhfe_pkg;

  localparam int MAX_NAME_BYTES   = 32;
  localparam int NAME_STORE_BYTES = 32;
  localparam int NAME_REGS        = 4;
  localparam int NAME_POS_W       = 6;
  localparam int COUNT_W          = 17;

  localparam logic [15:0] SIZE_LIMIT_RESET = 16'd16384;

  // register indexes
  localparam logic [2:0] REG_NAME_0      = 3'd0;
  localparam logic [2:0] REG_NAME_1      = 3'd1;
  localparam logic [2:0] REG_NAME_2      = 3'd2;
  localparam logic [2:0] REG_NAME_3      = 3'd3;
  localparam logic [2:0] REG_NAME_LENGTH = 3'd4;
  localparam logic [2:0] REG_SIZE_LIMIT  = 3'd5;

  // byte classes
  localparam logic [2:0] CLS_METHOD  = 3'd0;
  localparam logic [2:0] CLS_PATH    = 3'd1;
  localparam logic [2:0] CLS_LINE    = 3'd2;
  localparam logic [2:0] CLS_HEADER  = 3'd3;
  localparam logic [2:0] CLS_VALUE   = 3'd4;
  localparam logic [2:0] CLS_IGNORED = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;

  // characters
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_QMARK = 8'd63;
  localparam logic [7:0] CH_COLON = 8'd58;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] byte_class;
    logic       headers_end;
    logic [1:0] status;
    logic       header_found;
  } out_item_t;

  typedef struct packed {
    logic [NAME_STORE_BYTES*8-1:0] name_bytes;
    logic [NAME_POS_W-1:0]         name_length;
    logic [15:0]                   size_limit;
  } cfg_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

// ===== sv/http_header_field_extractor.sv =====
// an accepted byte is held in s1_item_r; its result is registered into out_item_r when it advances
// throughput: one byte per cycle while out_stall holds no result, limited by the single state update per byte
// a result held by out_stall still lets one more byte enter the input register
// reset: synchronous active-low rst_n clears parse state and both pipeline stages,
// sets size_limit to 16384 and clears the header name and its length
`timescale 1ns / 1ps
`include "http_header_field_extractor_macros.svh"

module http_header_field_extractor
  import hhfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  s1_item_r;
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      out_valid_r;
  logic      out_valid_nxt;
  logic      out_free;
  logic      s1_adv;
  logic      in_acc;

  hhfe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hhfe_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .upd    (s1_adv),
    .item   (s1_item_r),
    .result (out_item_nxt)
  );

  assign out_free      = !out_valid_r || !out_stall;
  assign s1_adv        = s1_valid_r && out_free;
  assign in_stall      = s1_valid_r && !out_free;
  assign in_acc        = in_valid && !in_stall;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  `HHFE_ASSERT_IMPL(a_hend_clean, out_valid_r && out_item_r.headers_end, out_item_r.status == ST_OK && out_item_r.byte_class == CLS_HEADER)
  `HHFE_ASSERT_IMPL(a_err_ignored, out_valid_r && out_item_r.status != ST_OK, out_item_r.byte_class == CLS_IGNORED)
  `HHFE_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_r)
  `HHFE_ASSERT_IMPL(a_stall_full, in_stall, s1_valid_r && out_valid_r)

endmodule

// ===== sv/hhfe_cfg_regs.sv =====
`timescale 1ns / 1ps

module hhfe_cfg_regs
  import hhfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output cfg_t        cfg
);

  logic [NAME_REGS-1:0][63:0] name_r;
  logic [NAME_POS_W-1:0]      name_length_r;
  logic [15:0]                size_limit_r;
  logic                       wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_r        <= '0;
      name_length_r <= '0;
      size_limit_r  <= SIZE_LIMIT_RESET;
    end else if (wr) begin
      case (cfg_index)
        REG_NAME_0:      name_r[0] <= cfg_data;
        REG_NAME_1:      name_r[1] <= cfg_data;
        REG_NAME_2:      name_r[2] <= cfg_data;
        REG_NAME_3:      name_r[3] <= cfg_data;
        REG_NAME_LENGTH: name_length_r <= cfg_data[NAME_POS_W-1:0];
        REG_SIZE_LIMIT:  size_limit_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg.name_bytes  = name_r;
  assign cfg.name_length = name_length_r;
  assign cfg.size_limit  = size_limit_r;

endmodule

// ===== sv/hhfe_parser.sv =====
`timescale 1ns / 1ps

module hhfe_parser
  import hhfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      upd,
  input  in_item_t  item,
  output out_item_t result
);

  typedef struct packed {
    logic [1:0]            crlf;
    logic [COUNT_W-1:0]    cnt;
    logic [1:0]            spaces;
    logic                  in_query;
    logic                  past_line;
    logic [NAME_POS_W-1:0] name_pos;
    logic                  mismatch;
    logic                  colon;
    logic                  in_value;
    logic                  skipping;
    logic                  found;
    logic                  finished;
    logic [1:0]            err;
  } pstate_t;

  pstate_t    st_r;
  pstate_t    st_nxt;
  pstate_t    cur;
  logic [7:0] c;
  logic [7:0] nb;
  logic       eol;
  logic       name_ok;
  logic [2:0] cls;
  logic       hend;

  assign c   = item.data_byte;
  assign cur = item.first_byte ? '0 : st_r;
  assign nb  = cfg.name_bytes[{cur.name_pos[4:0], 3'b000} +: 8];

  assign name_ok = (cur.name_pos < cfg.name_length)
                && (cur.name_pos < NAME_POS_W'(MAX_NAME_BYTES))
                && (cur.name_pos < NAME_POS_W'(NAME_STORE_BYTES))
                && (to_lower(nb) == to_lower(c));

  assign eol = (c == CH_LF) && (cur.crlf == 2'd1 || cur.crlf == 2'd3);

  always_comb begin
    st_nxt = cur;
    cls    = CLS_IGNORED;
    hend   = 1'b0;
    if (!cur.finished && cur.err == ST_OK) begin
      if (cur.cnt + 1'b1 > {1'b0, cfg.size_limit}) begin
        st_nxt.err = ST_TOO_LARGE;
      end else begin
        st_nxt.cnt = cur.cnt + 1'b1;
        if (c == CH_CR) begin
          st_nxt.crlf = (cur.crlf == 2'd2) ? 2'd3 : 2'd1;
        end else if (eol) begin
          st_nxt.crlf = 2'd2;
        end else begin
          st_nxt.crlf = 2'd0;
        end

        if (!cur.past_line) begin
          if (eol) begin
            if (cur.spaces < 2'd2) begin
              st_nxt.err = ST_MALFORMED;
            end else begin
              st_nxt.past_line = 1'b1;
              st_nxt.name_pos  = '0;
              st_nxt.mismatch  = 1'b0;
              st_nxt.colon     = 1'b0;
              st_nxt.in_value  = 1'b0;
              st_nxt.skipping  = 1'b0;
              cls              = CLS_LINE;
            end
          end else if (c == CH_CR || c == CH_LF) begin
            cls = CLS_LINE;
          end else if (cur.spaces == 2'd0) begin
            if (c == CH_SPACE) begin
              st_nxt.spaces = 2'd1;
              cls           = CLS_LINE;
            end else begin
              cls = CLS_METHOD;
            end
          end else if (cur.spaces == 2'd1) begin
            if (c == CH_SPACE) begin
              st_nxt.spaces = 2'd2;
              cls           = CLS_LINE;
            end else if (cur.in_query || c == CH_QMARK) begin
              st_nxt.in_query = 1'b1;
              cls             = CLS_LINE;
            end else begin
              cls = CLS_PATH;
            end
          end else begin
            cls = CLS_LINE;
          end
        end else begin
          cls = CLS_HEADER;
          if (eol) begin
            st_nxt.name_pos = '0;
            st_nxt.mismatch = 1'b0;
            st_nxt.colon    = 1'b0;
            st_nxt.in_value = 1'b0;
            st_nxt.skipping = 1'b0;
            if (cur.crlf == 2'd3) begin
              hend            = 1'b1;
              st_nxt.finished = 1'b1;
            end
          end else if (!cur.colon) begin
            if (c == CH_COLON) begin
              st_nxt.colon = 1'b1;
              if (!cur.mismatch && cur.name_pos == cfg.name_length && !cur.found) begin
                st_nxt.found    = 1'b1;
                st_nxt.in_value = 1'b1;
                st_nxt.skipping = 1'b1;
              end
            end else begin
              if (!name_ok) begin
                st_nxt.mismatch = 1'b1;
              end
              if (cur.name_pos != '1) begin
                st_nxt.name_pos = cur.name_pos + 1'b1;
              end
            end
          end else if (cur.in_value) begin
            if (c == CH_CR) begin
              st_nxt.in_value = 1'b0;
            end else if (cur.skipping && (c == CH_SPACE || c == CH_TAB)) begin
              cls = CLS_HEADER;
            end else begin
              st_nxt.skipping = 1'b0;
              cls             = CLS_VALUE;
            end
          end
        end
      end
      if (st_nxt.err != ST_OK) begin
        cls = CLS_IGNORED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (upd) begin
      st_r <= st_nxt;
    end
  end

  assign result.byte_class   = cls;
  assign result.headers_end  = hend;
  assign result.status       = st_nxt.err;
  assign result.header_found = st_nxt.found;

endmodule

// ===== test/http_header_field_extractor_test.sv =====
`timescale 1ns / 1ps

module http_header_field_extractor_test
  import hhfe_pkg::*;
();

  localparam logic [1:0] GOT_NONE    = 2'd0;
  localparam logic [1:0] GOT_CR      = 2'd1;
  localparam logic [1:0] GOT_CRLF    = 2'd2;
  localparam logic [1:0] GOT_CRLFCR  = 2'd3;
  localparam int         TARGET_BYTES = 1300;

  class byte_label_tracker;
    logic [63:0] name_word [4];
    logic [5:0]  name_len;
    logic [15:0] size_lim;
    logic [1:0]  crlf;
    int          count;
    int          spaces;
    bit          in_query, past_line, name_bad, colon, in_value, skip_blanks, found, done;
    logic [5:0]  name_pos;
    logic [1:0]  err;
    out_item_t   due_labels[$];
    int          failures;

    function new();
      for (int w = 0; w < 4; w++) begin
        name_word[w] = '0;
      end
      name_len = '0;
      size_lim = SIZE_LIMIT_RESET;
      failures = 0;
      clear_parse();
    endfunction

    function void start_line();
      name_pos = '0;
      name_bad = 0;
      colon = 0;
      in_value = 0;
      skip_blanks = 0;
    endfunction

    function void clear_parse();
      crlf = GOT_NONE;
      count = 0;
      spaces = 0;
      in_query = 0;
      past_line = 0;
      found = 0;
      done = 0;
      err = ST_OK;
      start_line();
    endfunction

    function logic [7:0] fold(logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5a) begin
        return c + 8'h20;
      end
      return c;
    endfunction

    function bit name_hit(logic [5:0] pos, logic [7:0] c);
      logic [7:0] nb;
      if (pos >= name_len || int'(pos) >= MAX_NAME_BYTES || int'(pos) >= 32) begin
        return 0;
      end
      nb = name_word[pos[4:3]][pos[2:0]*8 +: 8];
      return fold(nb) == fold(c);
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        REG_NAME_0: name_word[0] = v;
        REG_NAME_1: name_word[1] = v;
        REG_NAME_2: name_word[2] = v;
        REG_NAME_3: name_word[3] = v;
        REG_NAME_LENGTH: name_len = v[5:0];
        REG_SIZE_LIMIT: size_lim = v[15:0];
        default: ;
      endcase
    endfunction

    function void take_byte(in_item_t it);
      logic [7:0] c;
      logic [2:0] cls;
      logic [1:0] prev;
      bit         hend, eol;
      out_item_t  label;
      c = it.data_byte;
      cls = CLS_IGNORED;
      hend = 0;
      if (it.first_byte) begin
        clear_parse();
      end
      if (!done && err == ST_OK) begin
        if (count + 1 > int'(size_lim)) begin
          err = ST_TOO_LARGE;
        end else begin
          count++;
          prev = crlf;
          eol = (c == CH_LF) && (prev == GOT_CR || prev == GOT_CRLFCR);
          if (c == CH_CR) begin
            crlf = (prev == GOT_CRLF) ? GOT_CRLFCR : GOT_CR;
          end else if (eol) begin
            crlf = GOT_CRLF;
          end else begin
            crlf = GOT_NONE;
          end
          if (!past_line) begin
            if (eol) begin
              if (spaces < 2) begin
                err = ST_MALFORMED;
              end else begin
                past_line = 1;
                start_line();
                cls = CLS_LINE;
              end
            end else if (c == CH_CR || c == CH_LF) begin
              cls = CLS_LINE;
            end else if (spaces == 0) begin
              if (c == CH_SPACE) begin
                spaces = 1;
                cls = CLS_LINE;
              end else begin
                cls = CLS_METHOD;
              end
            end else if (spaces == 1) begin
              if (c == CH_SPACE) begin
                spaces = 2;
                cls = CLS_LINE;
              end else if (in_query || c == CH_QMARK) begin
                in_query = 1;
                cls = CLS_LINE;
              end else begin
                cls = CLS_PATH;
              end
            end else begin
              cls = CLS_LINE;
            end
          end else begin
            cls = CLS_HEADER;
            if (eol) begin
              start_line();
              if (prev == GOT_CRLFCR) begin
                hend = 1;
                done = 1;
              end
            end else if (!colon) begin
              if (c == CH_COLON) begin
                colon = 1;
                if (!name_bad && name_pos == name_len && !found) begin
                  found = 1;
                  in_value = 1;
                  skip_blanks = 1;
                end
              end else begin
                if (!name_hit(name_pos, c)) begin
                  name_bad = 1;
                end
                if (name_pos < 6'd63) begin
                  name_pos++;
                end
              end
            end else if (in_value) begin
              if (c == CH_CR) begin
                in_value = 0;
              end else if (skip_blanks && (c == CH_SPACE || c == CH_TAB)) begin
                cls = CLS_HEADER;
              end else begin
                skip_blanks = 0;
                cls = CLS_VALUE;
              end
            end
          end
          if (err != ST_OK) begin
            cls = CLS_IGNORED;
          end
        end
      end
      label.byte_class = cls;
      label.headers_end = hend;
      label.status = err;
      label.header_found = found;
      due_labels.push_back(label);
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, got);
        failures++;
      end
    endfunction

    function void check_label(out_item_t got);
      out_item_t want;
      if (due_labels.size() == 0) begin
        $display("%0t unexpected transaction: expected none, actual %p", $time, got);
        failures++;
        return;
      end
      want = due_labels.pop_front();
      compare_field("byte_class", want.byte_class, got.byte_class);
      compare_field("headers_end", want.headers_end, got.headers_end);
      compare_field("status", want.status, got.status);
      compare_field("header_found", want.header_found, got.header_found);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_NAME_0;
  logic [63:0] cfg_data = '0;

  byte_label_tracker board;
  in_item_t          stream[$];
  logic [7:0]        sought_name [64];
  int                sought_len;
  int                sent_total = 0;
  bit                idle_on = 1;

  http_header_field_extractor dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void put(logic [7:0] b, bit lead = 0);
    in_item_t it;
    it.data_byte = b;
    it.first_byte = lead;
    stream.push_back(it);
  endfunction

  function automatic void put_text(string s, bit lead = 0);
    for (int i = 0; i < s.len(); i++) begin
      put(s[i], lead && i == 0);
    end
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    bit letter;
    letter = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    if (letter && $urandom_range(0, 1) == 1) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0: c = 8'h30 + 8'($urandom_range(0, 9));
      1: c = "-";
      default: c = 8'h61 + 8'($urandom_range(0, 25));
    endcase
    return flip_case(c);
  endfunction

  function automatic logic [7:0] value_char(bit any);
    logic [7:0] c;
    c = any ? 8'($urandom_range(0, 255)) : 8'($urandom_range(33, 126));
    if (c == CH_CR) begin
      c = "v";
    end
    return c;
  endfunction

  function automatic void queue_header();
    int kind, n;
    kind = $urandom_range(0, 6);
    case (kind)
      0, 1, 2: begin
        for (int i = 0; i < sought_len; i++) begin
          put(flip_case(sought_name[i]));
        end
      end
      3: begin
        for (int i = 0; i + 1 < sought_len; i++) begin
          put(flip_case(sought_name[i]));
        end
        put(name_char());
        if ($urandom_range(0, 1) == 1) begin
          put(name_char());
        end
      end
      4: ;
      default: begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          put(name_char());
        end
      end
    endcase
    if ($urandom_range(0, 9) != 0) begin
      put(CH_COLON);
    end
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      put($urandom_range(0, 1) == 1 ? CH_SPACE : CH_TAB);
    end
    n = $urandom_range(0, 10);
    for (int i = 0; i < n; i++) begin
      put(value_char($urandom_range(0, 2) == 0));
    end
    if ($urandom_range(0, 5) == 0) begin
      put(CH_CR);
      put(value_char(0));
      put(value_char(1) == CH_LF ? 8'h41 : value_char(1));
    end
    put(CH_CR);
    put(CH_LF);
  endfunction

  function automatic void queue_request();
    int  shape, n;
    bit  lead;
    shape = $urandom_range(0, 9);
    lead = $urandom_range(0, 9) != 0;
    if (shape == 8) begin
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++) begin
        put(8'($urandom_range(0, 255)), i == 0 ? lead : $urandom_range(0, 15) == 0);
      end
      return;
    end
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      put(8'h41 + 8'($urandom_range(0, 25)), lead && i == 0);
    end
    if (shape != 7 || $urandom_range(0, 1) == 1) begin
      put(CH_SPACE);
    end
    put("/");
    n = $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      put(name_char());
    end
    if ($urandom_range(0, 1) == 1) begin
      put(CH_QMARK);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        put($urandom_range(0, 4) == 0 ? CH_QMARK : name_char());
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      put($urandom_range(0, 1) == 1 ? CH_CR : CH_LF);
    end
    if (shape != 7) begin
      put(CH_SPACE);
    end
    put_text("HTTP/1.1");
    put(CH_CR);
    put(CH_LF);
    n = $urandom_range(0, 4);
    for (int j = 0; j < n; j++) begin
      queue_header();
    end
    if (shape != 9) begin
      put(CH_CR);
      put(CH_LF);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        put(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic set_cfg(logic [2:0] idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic load_name(int len);
    logic [63:0] word [4];
    for (int w = 0; w < 4; w++) begin
      for (int b = 0; b < 8; b++) begin
        word[w][8*b +: 8] = sought_name[8*w + b];
      end
    end
    sought_len = len;
    set_cfg(REG_NAME_0, word[0]);
    set_cfg(REG_NAME_1, word[1]);
    set_cfg(REG_NAME_2, word[2]);
    set_cfg(REG_NAME_3, word[3]);
    set_cfg(REG_NAME_LENGTH, 64'(len));
  endtask

  task automatic pick_setting();
    int          len;
    logic [15:0] lim;
    case ($urandom_range(0, 6))
      0: len = 0;
      1: len = NAME_STORE_BYTES;
      2: len = 40;
      default: len = $urandom_range(1, 31);
    endcase
    for (int i = 0; i < 64; i++) begin
      sought_name[i] = i < len ? name_char() : 8'($urandom_range(0, 255));
    end
    load_name(len);
    case ($urandom_range(0, 8))
      0: lim = 16'd1;
      1: lim = 16'hffff;
      2: lim = 16'd0;
      3, 4, 5: lim = 16'($urandom_range(20, 300));
      default: lim = 16'($urandom_range(301, 65535));
    endcase
    set_cfg(REG_SIZE_LIMIT, 64'(lim));
    idle_on = $urandom_range(0, 3) != 0;
  endtask

  task automatic send_stream();
    int gap;
    while (stream.size() > 0) begin
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= stream[0];
      do @(posedge clk); while (in_stall);
      board.take_byte(stream.pop_front());
      sent_total++;
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (board.due_labels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_label(out_data);
    end
  end

  initial begin
    int hold;
    forever begin
      hold = idle_on ? $urandom_range(0, 7) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    board = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // size limit of one, extreme byte values
    set_cfg(REG_SIZE_LIMIT, 64'd1);
    put(8'h00, 1);
    put(8'hff);
    send_stream();
    drain_results();

    // short request with the sought header, blank skip, lone LF, CR ending the value
    for (int i = 0; i < 64; i++) begin
      sought_name[i] = 8'($urandom_range(0, 255));
    end
    sought_name[0] = "H";
    sought_name[1] = "o";
    sought_name[2] = "s";
    sought_name[3] = "t";
    load_name(4);
    set_cfg(REG_SIZE_LIMIT, 64'hffff);
    put_text("A / H", 1);
    put(CH_CR);
    put(CH_LF);
    put_text("hOsT:");
    put(CH_SPACE);
    put(CH_TAB);
    put_text("x");
    put(CH_LF);
    put(CH_CR);
    put_text("y");
    put(CH_CR);
    put(CH_LF);
    put(CH_CR);
    put(CH_LF);
    put_text("Z");
    send_stream();
    drain_results();

    while (sent_total < TARGET_BYTES) begin
      pick_setting();
      while (stream.size() < 90) begin
        queue_request();
      end
      send_stream();
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (board.failures == 0 && board.due_labels.size() == 0) begin
      $display("PASS http_header_field_extractor");
    end else begin
      $display("FAIL http_header_field_extractor");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL http_header_field_extractor");
    $finish;
  end

endmodule
